FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the scrambler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: rtl/core/asbs_pkg.sv
// ----------------------------------------------------------------------------
// asbs_pkg
// Constants, types and the shift-register step for the alternating step
// byte scrambler.
// ----------------------------------------------------------------------------
`default_nettype none

package asbs_pkg;

   localparam int unsigned GenWidth      = 128;
   localparam int unsigned SeedWidth     = 64;
   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned CsrAddrWidth  = 4;
   localparam int unsigned CsrDataWidth  = 64;

   // Register map: one 64-bit seed word every 8 bytes, selected by address bit 3
   localparam int unsigned CsrIndexBit   = 3;
   localparam logic        CsrSeedLow    = 1'b0;
   localparam logic        CsrSeedHigh   = 1'b1;

   // Feedback taps, applied to the high word
   localparam logic [SeedWidth-1:0] Tap128 = 64'he100000000000000;
   localparam logic [SeedWidth-1:0] Tap127 = 64'h6000000000000000;
   localparam logic [SeedWidth-1:0] Tap126 = 64'h2a40000000000000;

   localparam logic [GenWidth-1:0] ClkDefault = {64'hf01f4fdee002f1f8, 64'h17ee9999ab123450};
   localparam logic [GenWidth-1:0] RegAInit   = {64'h009feb12821dde00, 64'h7fe1105ab10c5e4f};
   localparam logic [GenWidth-1:0] RegBInit   = {64'h00ca1fee6caf0900, 64'h1c0fe2ca3e3c9fe4};

   // Warm-up: register steps advanced per cycle and per-register step totals
   localparam int unsigned StepsPerCycle  = 8;
   localparam int unsigned WarmClk        = 3334;
   localparam int unsigned WarmA          = 2736;
   localparam int unsigned WarmB          = 4101;
   localparam int unsigned WarmMax        = 4101;
   localparam int unsigned WarmCycles     = (WarmMax + StepsPerCycle - 1) / StepsPerCycle;
   localparam int unsigned WarmLimitInt   = WarmCycles * StepsPerCycle;
   localparam int unsigned WarmCountWidth = $clog2(WarmLimitInt + StepsPerCycle);

   localparam logic [WarmCountWidth-1:0] WarmClkSteps = WarmCountWidth'(WarmClk);
   localparam logic [WarmCountWidth-1:0] WarmASteps   = WarmCountWidth'(WarmA);
   localparam logic [WarmCountWidth-1:0] WarmBSteps   = WarmCountWidth'(WarmB);
   localparam logic [WarmCountWidth-1:0] WarmLimit    = WarmCountWidth'(WarmLimitInt);
   localparam logic [WarmCountWidth-1:0] WarmIncrement = WarmCountWidth'(StepsPerCycle);

   typedef enum logic {
      ActRestart  = 1'b0,
      ActScramble = 1'b1
   } action_type;

   typedef struct packed {
      logic [GenWidth-1:0] clk_reg;
      logic [GenWidth-1:0] reg_a;
      logic [GenWidth-1:0] reg_b;
   } gen_state_type;

   // Shift right by one across both words, then fold the tap into the high
   // word when the new bit 0 is set.
   function automatic logic [GenWidth-1:0] gen_step(input logic [GenWidth-1:0] value,
                                                    input logic [SeedWidth-1:0] tap);
      logic [GenWidth-1:0] shifted;
      shifted = {1'b0, value[GenWidth-1:1]};
      if (shifted[0]) begin
         shifted[GenWidth-1:SeedWidth] = shifted[GenWidth-1:SeedWidth] ^ tap;
      end
      return shifted;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/alternating_step_byte_scrambler_unit.sv
// ----------------------------------------------------------------------------
// alternating_step_byte_scrambler_unit
// Alternating step generator keystream scrambler, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel req_*: req_action selects restart (0) or scramble (1);
//   req_data_in is the byte to scramble. Output channel rsp_*: one
//   rsp_data_out for every input transfer, in order; zero for a restart.
//   csr_* is an APB-style port: seed_low at 0x0, seed_high at 0x8, both
//   64 bits. The seed is folded into the clock register at the next restart.
// Pipeline and throughput
//   A scramble transfer is registered in the input register, then
//   scrambled in one pass into the result register; a new byte is taken
//   every cycle while rsp_stall is low and no restart is warming up.
//   A restart reloads the three generators and warms them up eight steps a
//   cycle until the longest warm-up (4101 steps of register B) is done,
//   then loads its zero result into the result register. req_stall stays
//   high meanwhile once the input register holds the next item.
// Reset and stall
//   Reset clears the generators (scrambling then passes bytes unchanged),
//   the seeds and both pipeline registers. While rsp_stall is high the
//   result holds and the input register fills, then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module alternating_step_byte_scrambler_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input channel
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic                                  req_action,
   input  wire logic [asbs_pkg::ByteWidth-1:0]        req_data_in,
   // result channel
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic [asbs_pkg::ByteWidth-1:0]        rsp_data_out,
   // configuration port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [asbs_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire logic [asbs_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output      logic [asbs_pkg::CsrDataWidth-1:0]     csr_prdata,
   output      logic                                  csr_pready
);

`include "assert_macros.svh"

   // ---------------------------------------------------------------- signals
   logic                                   in_valid_ff, in_valid_in;
   asbs_pkg::action_type                   in_action_ff;
   logic [asbs_pkg::ByteWidth-1:0]         in_data_ff;

   logic                                   out_valid_ff, out_valid_in;
   logic [asbs_pkg::ByteWidth-1:0]         out_data_ff, out_data_in;
   logic                                   out_load;

   logic                                   warm_active_ff, warm_active_in;
   logic [asbs_pkg::WarmCountWidth-1:0]    warmup_count_ff, warmup_count_in;

   asbs_pkg::gen_state_type                gen_ff, gen_in, gen_step_out, gen_restart;
   logic [asbs_pkg::ByteWidth-1:0]         keystream;

   logic [asbs_pkg::SeedWidth-1:0]         seed_low_ff, seed_low_in;
   logic [asbs_pkg::SeedWidth-1:0]         seed_high_ff, seed_high_in;

   logic                                   req_accept;
   logic                                   out_free;
   logic                                   proc_fire;
   logic                                   proc_restart;
   logic                                   proc_scramble;
   logic                                   warm_done;
   logic                                   warm_run;
   logic                                   warm_emit;
   logic                                   csr_write;
   logic                                   csr_index;

   // --------------------------------------------------------------- handshake
   assign out_free      = !out_valid_ff || !rsp_stall;
   assign proc_fire     = in_valid_ff && !warm_active_ff && out_free;
   assign proc_restart  = proc_fire && (in_action_ff == asbs_pkg::ActRestart);
   assign proc_scramble = proc_fire && (in_action_ff == asbs_pkg::ActScramble);

   assign warm_done = (warmup_count_ff >= asbs_pkg::WarmLimit);
   assign warm_run  = warm_active_ff && !warm_done;
   assign warm_emit = warm_active_ff && warm_done && out_free;

   assign req_stall  = in_valid_ff && !proc_fire;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;

   // ------------------------------------------------------------ step network
   // Eight chained register steps. During warm-up each register advances
   // only while its own step total has not been reached; when scrambling,
   // the clock register picks which data register advances.
   always_comb begin
      logic [asbs_pkg::WarmCountWidth-1:0] step_idx;
      logic                                sel;
      gen_step_out = gen_ff;
      keystream    = '0;
      step_idx     = '0;
      sel          = 1'b0;
      for (int k = 0; k < asbs_pkg::StepsPerCycle; k++) begin
         step_idx = warmup_count_ff + asbs_pkg::WarmCountWidth'(k);
         if (warm_active_ff) begin
            if (step_idx < asbs_pkg::WarmClkSteps) begin
               gen_step_out.clk_reg = asbs_pkg::gen_step(gen_step_out.clk_reg,
                                                         asbs_pkg::Tap128);
            end
            if (step_idx < asbs_pkg::WarmASteps) begin
               gen_step_out.reg_a = asbs_pkg::gen_step(gen_step_out.reg_a, asbs_pkg::Tap127);
            end
            if (step_idx < asbs_pkg::WarmBSteps) begin
               gen_step_out.reg_b = asbs_pkg::gen_step(gen_step_out.reg_b, asbs_pkg::Tap126);
            end
         end else begin
            gen_step_out.clk_reg = asbs_pkg::gen_step(gen_step_out.clk_reg, asbs_pkg::Tap128);
            sel = gen_step_out.clk_reg[0];
            if (sel) begin
               gen_step_out.reg_a = asbs_pkg::gen_step(gen_step_out.reg_a, asbs_pkg::Tap127);
               keystream[k]       = gen_step_out.reg_a[0];
            end else begin
               gen_step_out.reg_b = asbs_pkg::gen_step(gen_step_out.reg_b, asbs_pkg::Tap126);
               keystream[k]       = gen_step_out.reg_b[0];
            end
         end
      end
   end

   assign gen_restart.clk_reg = asbs_pkg::ClkDefault ^ {seed_high_ff, seed_low_ff};
   assign gen_restart.reg_a   = asbs_pkg::RegAInit;
   assign gen_restart.reg_b   = asbs_pkg::RegBInit;

   // ------------------------------------------------------------ next state
   always_comb begin
      in_valid_in     = req_accept || (in_valid_ff && !proc_fire);

      out_load        = proc_scramble || warm_emit;
      out_valid_in    = out_load || (out_valid_ff && rsp_stall);
      out_data_in     = proc_scramble ? (in_data_ff ^ keystream) : '0;

      warm_active_in  = warm_active_ff;
      warmup_count_in = warmup_count_ff;
      gen_in          = gen_ff;

      if (proc_restart) begin
         warm_active_in  = 1'b1;
         warmup_count_in = '0;
         gen_in          = gen_restart;
      end else if (warm_run) begin
         warmup_count_in = warmup_count_ff + asbs_pkg::WarmIncrement;
         gen_in          = gen_step_out;
      end else if (warm_emit) begin
         warm_active_in  = 1'b0;
      end else if (proc_scramble) begin
         gen_in          = gen_step_out;
      end
   end

   // --------------------------------------------------------- configuration
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[asbs_pkg::CsrIndexBit];
   assign csr_pready = 1'b1;

   always_comb begin
      seed_low_in  = seed_low_ff;
      seed_high_in = seed_high_ff;
      if (csr_write) begin
         unique case (csr_index)
            asbs_pkg::CsrSeedLow:  seed_low_in  = csr_pwdata;
            asbs_pkg::CsrSeedHigh: seed_high_in = csr_pwdata;
            default:               seed_low_in  = seed_low_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         asbs_pkg::CsrSeedLow:  csr_prdata = seed_low_ff;
         asbs_pkg::CsrSeedHigh: csr_prdata = seed_high_ff;
         default:               csr_prdata = '0;
      endcase
   end

   // --------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         warm_active_ff  <= 1'b0;
         warmup_count_ff <= '0;
         gen_ff          <= '0;
         seed_low_ff     <= '0;
         seed_high_ff    <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         warm_active_ff  <= warm_active_in;
         warmup_count_ff <= warmup_count_in;
         gen_ff          <= gen_in;
         seed_low_ff     <= seed_low_in;
         seed_high_ff    <= seed_high_in;
      end
   end

   // payload: hold unless a transfer loads it
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= asbs_pkg::action_type'(req_action);
         in_data_ff   <= req_data_in;
      end
      if (out_load) begin
         out_data_ff  <= out_data_in;
      end
   end

   // -------------------------------------------------------------- assertions
   `ASSERT_IMPLY(a_warm_count_bound, clock, reset, 1'b1, warmup_count_ff <= asbs_pkg::WarmLimit)
   `ASSERT_NEXT(a_restart_starts_warm, clock, reset, proc_restart, warm_active_ff && warmup_count_ff == '0)
   `ASSERT_NEXT(a_warm_emits_zero, clock, reset, warm_emit, rsp_valid && rsp_data_out == '0 && !warm_active_ff)
   `ASSERT_IMPLY(a_no_stall_when_empty, clock, reset, !in_valid_ff, !req_stall)

endmodule

`default_nettype wire
